@@ hdl/spectral_deconvolution_bin_assert.svh @@
// Assertion helpers for the spectral deconvolution bin.
`ifndef SPECTRAL_DECONVOLUTION_BIN_ASSERT_SVH
`define SPECTRAL_DECONVOLUTION_BIN_ASSERT_SVH

// Check a condition at every clock edge out of reset.
`define SDB_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define SDB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sdb_pkg.sv @@
package sdb_pkg;

    localparam int DW   = 32;          // field width
    localparam int CW   = DW + 1;      // padded kernel real part
    localparam int PRW  = 2 * DW + 1;  // magnitude products
    localparam int SUMW = PRW + 2;     // signed sum of two products
    localparam int DENW = PRW + 1;     // divisor C*C + D*D
    localparam int NMW  = PRW;         // numerator magnitude
    localparam int NW   = 3 * DW;      // numerator times weight
    localparam int QW   = DW + 1;      // quotient bits kept
    localparam int CMPW = DENW + QW;   // shifted divisor

    typedef struct packed {
        logic [NW-1:0] rem;
        logic [QW-1:0] q;
        logic          neg;
        logic          ovf;
    } lane_t;

    typedef struct packed {
        logic [DENW-1:0] den;
        lane_t           re;
        lane_t           im;
        logic            zero;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
    } item_t;

endpackage

@@ hdl/sdb_front.sv @@
module sdb_front
    import sdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld,
    input  logic signed [DW-1:0] sig_re,
    input  logic signed [DW-1:0] sig_im,
    input  logic signed [DW-1:0] ker_re,
    input  logic signed [DW-1:0] ker_im,
    input  logic signed [DW-1:0] filter_weight,
    input  logic signed [DW-1:0] kernel_padding,
    output logic                 out_vld,
    output item_t                out_item
);

    // stage 1: padding
    logic                 s1_vld_reg;
    logic signed [DW-1:0] s1_a_reg, s1_b_reg, s1_d_reg, s1_w_reg;
    logic signed [CW-1:0] s1_c_reg;
    logic signed [CW-1:0] s1_c_next;

    // stage 2: magnitude products
    logic             s2_vld_reg;
    logic [PRW-1:0]   s2_ac_reg, s2_bd_reg, s2_bc_reg, s2_ad_reg, s2_cc_reg, s2_dd_reg;
    logic             s2_sac_reg, s2_sbd_reg, s2_sbc_reg, s2_sad_reg, s2_sw_reg;
    logic [DW-1:0]    s2_wm_reg, s2_a_reg, s2_b_reg;
    logic             s2_zero_reg;
    logic [DW-1:0]    am, bm, dm, wm;
    logic [CW-1:0]    cm;

    // stage 3: numerators and divisor
    logic             s3_vld_reg;
    logic [NMW-1:0]   s3_nre_reg, s3_nim_reg;
    logic             s3_negre_reg, s3_negim_reg;
    logic [DENW-1:0]  s3_den_reg;
    logic [DW-1:0]    s3_wm_reg, s3_a_reg, s3_b_reg;
    logic             s3_zero_reg;
    logic signed [SUMW-1:0] t1, t2, t3, t4, nre_s, nim_s;

    // stage 4: partial products with the weight
    logic             s4_vld_reg;
    logic [2*DW-1:0]  s4_relo_reg, s4_imlo_reg;
    logic [PRW-1:0]   s4_rehi_reg, s4_imhi_reg;
    logic             s4_negre_reg, s4_negim_reg;
    logic [DENW-1:0]  s4_den_reg;
    logic [DW-1:0]    s4_a_reg, s4_b_reg;
    logic             s4_zero_reg;

    // stage 5: full numerator
    logic             s5_vld_reg;
    logic [NW-1:0]    s5_nre_reg, s5_nim_reg;
    logic             s5_negre_reg, s5_negim_reg;
    logic [DENW-1:0]  s5_den_reg;
    logic [DW-1:0]    s5_a_reg, s5_b_reg;
    logic             s5_zero_reg;

    // stage 6: overflow check
    logic             s6_vld_reg;
    item_t            s6_item_reg;
    logic [CMPW-1:0]  den_top;

    assign s1_c_next = CW'(ker_re) + CW'(kernel_padding);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_comb
    begin
        am = s1_a_reg[DW-1] ? DW'(-s1_a_reg) : DW'(s1_a_reg);
        bm = s1_b_reg[DW-1] ? DW'(-s1_b_reg) : DW'(s1_b_reg);
        dm = s1_d_reg[DW-1] ? DW'(-s1_d_reg) : DW'(s1_d_reg);
        wm = s1_w_reg[DW-1] ? DW'(-s1_w_reg) : DW'(s1_w_reg);
        cm = s1_c_reg[CW-1] ? CW'(-s1_c_reg) : CW'(s1_c_reg);
    end

    always_comb
    begin
        t1 = s2_sac_reg ? -$signed({2'b00, s2_ac_reg}) : $signed({2'b00, s2_ac_reg});
        t2 = s2_sbd_reg ? -$signed({2'b00, s2_bd_reg}) : $signed({2'b00, s2_bd_reg});
        t3 = s2_sbc_reg ? -$signed({2'b00, s2_bc_reg}) : $signed({2'b00, s2_bc_reg});
        t4 = s2_sad_reg ? -$signed({2'b00, s2_ad_reg}) : $signed({2'b00, s2_ad_reg});
        nre_s = t1 + t2;
        nim_s = t3 + t4;
    end

    assign den_top = CMPW'(s5_den_reg) << QW;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg <= sig_re;
            s1_b_reg <= sig_im;
            s1_c_reg <= s1_c_next;
            s1_d_reg <= ker_im;
            s1_w_reg <= filter_weight;

            s2_ac_reg   <= PRW'(am) * PRW'(cm);
            s2_bd_reg   <= PRW'(bm) * PRW'(dm);
            s2_bc_reg   <= PRW'(bm) * PRW'(cm);
            s2_ad_reg   <= PRW'(am) * PRW'(dm);
            s2_cc_reg   <= PRW'(cm) * PRW'(cm);
            s2_dd_reg   <= PRW'(dm) * PRW'(dm);
            s2_sac_reg  <= s1_a_reg[DW-1] ^ s1_c_reg[CW-1];
            s2_sbd_reg  <= s1_b_reg[DW-1] ^ s1_d_reg[DW-1];
            s2_sbc_reg  <= s1_b_reg[DW-1] ^ s1_c_reg[CW-1];
            s2_sad_reg  <= ~(s1_a_reg[DW-1] ^ s1_d_reg[DW-1]);
            s2_sw_reg   <= s1_w_reg[DW-1];
            s2_wm_reg   <= wm;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_zero_reg <= (s1_c_reg == '0) && (s1_d_reg == '0);

            s3_nre_reg   <= nre_s[SUMW-1] ? NMW'(-nre_s) : NMW'(nre_s);
            s3_nim_reg   <= nim_s[SUMW-1] ? NMW'(-nim_s) : NMW'(nim_s);
            s3_negre_reg <= nre_s[SUMW-1] ^ s2_sw_reg;
            s3_negim_reg <= nim_s[SUMW-1] ^ s2_sw_reg;
            s3_den_reg   <= DENW'(s2_cc_reg) + DENW'(s2_dd_reg);
            s3_wm_reg    <= s2_wm_reg;
            s3_a_reg     <= s2_a_reg;
            s3_b_reg     <= s2_b_reg;
            s3_zero_reg  <= s2_zero_reg;

            // split the numerator so each multiply stays near 32 by 32
            s4_relo_reg  <= (2*DW)'(s3_nre_reg[DW-1:0]) * (2*DW)'(s3_wm_reg);
            s4_imlo_reg  <= (2*DW)'(s3_nim_reg[DW-1:0]) * (2*DW)'(s3_wm_reg);
            s4_rehi_reg  <= PRW'(s3_nre_reg[NMW-1:DW]) * PRW'(s3_wm_reg);
            s4_imhi_reg  <= PRW'(s3_nim_reg[NMW-1:DW]) * PRW'(s3_wm_reg);
            s4_negre_reg <= s3_negre_reg;
            s4_negim_reg <= s3_negim_reg;
            s4_den_reg   <= s3_den_reg;
            s4_a_reg     <= s3_a_reg;
            s4_b_reg     <= s3_b_reg;
            s4_zero_reg  <= s3_zero_reg;

            s5_nre_reg   <= NW'({s4_rehi_reg, {DW{1'b0}}}) + NW'(s4_relo_reg);
            s5_nim_reg   <= NW'({s4_imhi_reg, {DW{1'b0}}}) + NW'(s4_imlo_reg);
            s5_negre_reg <= s4_negre_reg;
            s5_negim_reg <= s4_negim_reg;
            s5_den_reg   <= s4_den_reg;
            s5_a_reg     <= s4_a_reg;
            s5_b_reg     <= s4_b_reg;
            s5_zero_reg  <= s4_zero_reg;

            // a quotient that needs more than QW bits saturates
            s6_item_reg.den    <= s5_den_reg;
            s6_item_reg.re.rem <= s5_nre_reg;
            s6_item_reg.re.q   <= '0;
            s6_item_reg.re.neg <= s5_negre_reg;
            s6_item_reg.re.ovf <= CMPW'(s5_nre_reg) >= den_top;
            s6_item_reg.im.rem <= s5_nim_reg;
            s6_item_reg.im.q   <= '0;
            s6_item_reg.im.neg <= s5_negim_reg;
            s6_item_reg.im.ovf <= CMPW'(s5_nim_reg) >= den_top;
            s6_item_reg.zero   <= s5_zero_reg;
            s6_item_reg.a      <= s5_a_reg;
            s6_item_reg.b      <= s5_b_reg;
        end
    end

    assign out_vld  = s6_vld_reg;
    assign out_item = s6_item_reg;

endmodule

@@ hdl/sdb_div_step.sv @@
module sdb_div_step
    import sdb_pkg::*;
#(
    parameter int BIT = QW - 1
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  vld,
    input  item_t item,
    output logic  out_vld,
    output item_t out_item
);

    logic            vld_reg;
    item_t           item_reg;
    item_t           item_next;
    logic [CMPW-1:0] dsh;

    function automatic lane_t lane_step(lane_t l, logic [CMPW-1:0] d);
        lane_t r;
        r = l;
        if (CMPW'(l.rem) >= d)
        begin
            r.rem    = l.rem - d[NW-1:0];
            r.q[BIT] = 1'b1;
        end
        return r;
    endfunction

    assign dsh = CMPW'(item.den) << BIT;

    always_comb
    begin
        item_next    = item;
        item_next.re = lane_step(item.re, dsh);
        item_next.im = lane_step(item.im, dsh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

@@ hdl/spectral_deconvolution_bin.sv @@
// Pipeline: 6 front stages, 33 restoring division stages, 1 output register.
// Throughput: one bin per cycle while no output stall freezes the pipeline;
// each division stage retires one quotient bit.
// An output stall freezes the whole pipeline; no beat is lost or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline and clears kernel_padding.
`include "spectral_deconvolution_bin_assert.svh"

module spectral_deconvolution_bin
    import sdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [DW-1:0] sig_re,
    input  logic signed [DW-1:0] sig_im,
    input  logic signed [DW-1:0] ker_re,
    input  logic signed [DW-1:0] ker_im,
    input  logic signed [DW-1:0] filter_weight,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [DW-1:0] out_re,
    output logic signed [DW-1:0] out_im,
    output logic                 zero_divisor,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic signed [DW-1:0] cfg_data
);

    logic                 en;
    logic signed [DW-1:0] padding_reg;
    logic                 out_valid_reg;
    logic [DW-1:0]        out_re_reg, out_im_reg;
    logic                 zero_reg;
    logic [DW-1:0]        re_next, im_next;

    logic  stg_vld [QW+1];
    item_t stg_item [QW+1];
    item_t last;

    assign en        = !out_valid_reg || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            padding_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            padding_reg <= cfg_data;
        end
    end

    sdb_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .vld            (in_valid),
        .sig_re         (sig_re),
        .sig_im         (sig_im),
        .ker_re         (ker_re),
        .ker_im         (ker_im),
        .filter_weight  (filter_weight),
        .kernel_padding (padding_reg),
        .out_vld        (stg_vld[0]),
        .out_item       (stg_item[0])
    );

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        sdb_div_step #(
            .BIT (QW - 1 - k)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld      (stg_vld[k]),
            .item     (stg_item[k]),
            .out_vld  (stg_vld[k+1]),
            .out_item (stg_item[k+1])
        );
    end

    function automatic logic [DW-1:0] saturate(lane_t l);
        logic [DW-1:0] r;
        if (l.neg)
        begin
            if (l.ovf || l.q > {1'b0, 1'b1, {(DW-1){1'b0}}})
                r = {1'b1, {(DW-1){1'b0}}};
            else
                r = DW'(-l.q);
        end
        else
        begin
            if (l.ovf || l.q > {2'b00, {(DW-1){1'b1}}})
                r = {1'b0, {(DW-1){1'b1}}};
            else
                r = l.q[DW-1:0];
        end
        return r;
    endfunction

    assign last = stg_item[QW];

    always_comb
    begin
        if (last.zero)
        begin
            re_next = last.a;
            im_next = last.b;
        end
        else
        begin
            re_next = saturate(last.re);
            im_next = saturate(last.im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stg_vld[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_re_reg <= re_next;
            out_im_reg <= im_next;
            zero_reg   <= last.zero;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_re       = out_re_reg;
    assign out_im       = out_im_reg;
    assign zero_divisor = zero_reg;

    // a result beat leaves only when the sink took it
    `SDB_ASSERT(a_fell_taken, !$fell(out_valid_reg) || $past(!out_stall), "result beat dropped")
    // a frozen pipeline keeps its last division stage
    `SDB_ASSERT_NEXT(a_hold_last, !en, $stable(stg_vld[QW]) && $stable(stg_item[QW]), "stage moved during stall")

endmodule

@@ tb/sv/sdb_checker.sv @@
`timescale 1ns / 100ps

module sdb_checker
    import sdb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [DW-1:0] sig_re,
    input  logic signed [DW-1:0] sig_im,
    input  logic signed [DW-1:0] ker_re,
    input  logic signed [DW-1:0] ker_im,
    input  logic signed [DW-1:0] filter_weight,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [DW-1:0] out_re,
    input  logic signed [DW-1:0] out_im,
    input  logic                 zero_divisor,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic signed [DW-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 zdiv;
    } bin_t;

    bin_t                 expected_bins[$];
    logic signed [DW-1:0] padding;

    // Saturating truncated quotient of num*w / den.
    function automatic logic signed [DW-1:0] scaled_quot(
        logic signed [67:0] num, logic signed [DW-1:0] w, logic [66:0] den);
        logic         neg;
        logic [67:0]  nmag;
        logic [31:0]  wmag;
        logic [99:0]  prod;
        logic [99:0]  q;
        neg  = (num < 0) != (w < 0);
        nmag = num < 0 ? -num : num;
        wmag = w < 0 ? -w : w;
        prod = nmag * wmag;
        q    = prod / den;
        if (neg)
            return q > 100'h80000000 ? 32'sh80000000 : -q[31:0];
        return q > 100'h7FFFFFFF ? 32'sh7FFFFFFF : q[31:0];
    endfunction

    function automatic bin_t deconvolve(
        logic signed [DW-1:0] a, logic signed [DW-1:0] b,
        logic signed [DW-1:0] kr, logic signed [DW-1:0] ki,
        logic signed [DW-1:0] w, logic signed [DW-1:0] pad);
        bin_t               r;
        logic signed [67:0] c, d, nre, nim;
        logic [66:0]        den;
        c = kr + pad;
        d = ki;
        if (c == 0 && d == 0)
        begin
            r.re = a; r.im = b; r.zdiv = 1'b1;
            return r;
        end
        den  = c * c + d * d;
        nre  = a * c + b * d;
        nim  = b * c - a * d;
        r.re = scaled_quot(nre, w, den);
        r.im = scaled_quot(nim, w, den);
        r.zdiv = 1'b0;
        return r;
    endfunction

    assign pending = expected_bins.size();

    always @(posedge clk or negedge rst_n)
    begin
        bin_t want;
        if (!rst_n)
        begin
            padding <= '0;
            fail_count <= 0;
            expected_bins.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bins.size() == 0)
                begin
                    $display("%0t: unexpected beat re=%h im=%h z=%b",
                             $time, out_re, out_im, zero_divisor);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (want.re !== out_re || want.im !== out_im ||
                        want.zdiv !== zero_divisor)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h z=%b got re=%h im=%h z=%b",
                                 $time, want.re, want.im, want.zdiv,
                                 out_re, out_im, zero_divisor);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_bins.insert(expected_bins.size(),
                                     deconvolve(sig_re, sig_im, ker_re, ker_im,
                                                filter_weight, padding));
            if (cfg_valid && cfg_ready)
                padding <= cfg_data;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import sdb_pkg::*;

    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [DW-1:0] sig_re = '0, sig_im = '0, ker_re = '0, ker_im = '0;
    logic signed [DW-1:0] filter_weight = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [DW-1:0] out_re, out_im;
    logic                 zero_divisor;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic signed [DW-1:0] cfg_data = '0;
    int                   fail_count, pending;
    int                   cycles = 0;
    bit                   hold_off = 1'b0;

    always #5 clk = ~clk;

    spectral_deconvolution_bin dut (.*);
    sdb_checker chk (.*);

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
            4, 5: return $signed($urandom_range(0, 65535)) - 32'sd32768;
            6, 7: return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_bin(logic [31:0] a, logic [31:0] b, logic [31:0] kr,
                            logic [31:0] ki, logic [31:0] w);
        sig_re <= a; sig_im <= b; ker_re <= kr; ker_im <= ki; filter_weight <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_in();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        idle_in();
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic write_padding(logic [31:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_bins(int count, logic [31:0] pad);
        int burst;
        int k;
        k = 0;
        while (k < count)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                // Hit the zero divisor now and then, using the padding.
                if ($urandom_range(0, 15) == 0)
                    send_bin(pick_value(), pick_value(), -pad, 32'h0, pick_value());
                else
                    send_bin(pick_value(), pick_value(), pick_value(), pick_value(),
                             pick_value());
                k++;
            end
            idle_in();
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            case ((cycles / 200) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
    end

    initial
    begin
        logic [31:0] pads[4];
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, zero divisor, unity kernel, saturation.
        send_bin(32'h00010000, 32'h00020000, 32'h00010000, 32'h0, 32'h00010000);
        send_bin(32'h12345678, 32'h87654321, 32'h0, 32'h0, 32'h00010000);
        send_bin(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h80000000);
        send_bin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 32'h0, 32'h7FFFFFFF);
        send_bin(32'h80000000, 32'h80000000, 32'h00000001, 32'h0, 32'h7FFFFFFF);
        send_bin(32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'h1, 32'h80000000);
        send_bin(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_bin(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_bin(32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
        send_bin(32'h00030000, 32'hFFFD0000, 32'h00000000, 32'h00020000, 32'h00008000);
        send_bin(32'h0, 32'h0, 32'h00010000, 32'h00010000, 32'h7FFFFFFF);
        send_bin(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        drain();

        write_padding(32'h7FFFFFFF);
        send_bin(32'h00010000, 32'h0, 32'h80000001, 32'h0, 32'h00010000);
        send_bin(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF);
        send_bin(32'h80000000, 32'h1, 32'h80000000, 32'h0, 32'h80000000);
        drain();
        write_padding(32'h80000000);
        send_bin(32'h00050000, 32'h00060000, 32'h80000000, 32'h0, 32'h00010000);
        send_bin(32'h00050000, 32'h00060000, 32'h80000000, 32'h0, 32'h00020000);
        send_bin(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        drain();

        pads[0] = 32'h0;
        pads[1] = 32'h00010000;
        pads[2] = $urandom;
        pads[3] = 32'hFFFF8000;
        for (int p = 0; p < 4; p++)
        begin
            write_padding(pads[p]);
            if (p == 1)
            begin
                // Long receiver hold-off while bins keep arriving.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (150) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    random_bins(110, pads[p]);
                join
            end
            else
                random_bins(110, pads[p]);
            drain();
        end

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
